@@ hdl/fsst_pkg.sv @@
// Shared types and constants for the flow shop start time pipeline.
`timescale 1ns / 1ps
`default_nettype none

package fsst_pkg;

	localparam int MACHINES = 8;
	localparam int IDX_W    = $clog2(MACHINES);
	localparam int CNT_W    = 4;
	localparam int PROC_W   = 16;
	localparam int TIME_W   = 24;
	localparam int MASK_W   = MACHINES * MACHINES;
	localparam int CFG_W    = 64;

	// Configuration register indexes
	typedef enum logic {
		REG_PRED_MASK     = 1'b0,
		REG_MACHINES_USED = 1'b1
	} reg_idx_t;

	// Job record carried from cell to cell
	typedef struct packed {
		logic                             first;
		logic                             sat;
		logic [MACHINES-1:0][PROC_W-1:0] proc;
		logic [MACHINES-1:0][TIME_W-1:0] start;
		logic [MACHINES-1:0][TIME_W-1:0] finish;
	} job_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic                advance;
		logic                active;
		logic [IDX_W-1:0]    idx;
		logic [MACHINES-1:0] pred;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/flow_shop_start_times_top.sv @@
// Top level: configuration registers and the row of machine cells.
//
//  Channel  Handshake            Payload
//  s_       s_tvalid/s_tready    s_tdata proc_0..proc_7, s_tuser first_job
//  m_       m_tvalid/m_tready    m_tdata start_0..start_7, m_tuser saturated
//  cfg_     cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One job enters per cycle while the row advances; each job walks the row of cells,
// one machine per cell, and leaves from the last cell's stage register.
// All stages move together; they hold only while the output register is full
// and m_tready is low. cfg_ready is always high.
// Reset clears the stored previous-job finishes, pred_mask to zero and
// machines_used to eight.
`timescale 1ns / 1ps
`default_nettype none

module flow_shop_start_times_top
	import fsst_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [MACHINES*PROC_W-1:0]   s_tdata,  // proc_0 .. proc_7
	input  logic                         s_tuser,  // first_job
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [MACHINES*TIME_W-1:0]   m_tdata,  // start_0 .. start_7
	output logic                         m_tuser,  // saturated
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	logic [MASK_W-1:0]   pred_mask_q;
	logic [CNT_W-1:0]    machines_used_q;
	logic [CNT_W-1:0]    used;
	logic [MACHINES-1:0] active;
	logic                advance;
	logic                vld [0:MACHINES];
	job_t                job [0:MACHINES];
	cell_ctl_t           ctl [0:MACHINES-1];

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_mask_q     <= '0;
			machines_used_q <= CNT_W'(MACHINES);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PRED_MASK:     pred_mask_q     <= cfg_data[MASK_W-1:0];
				REG_MACHINES_USED: machines_used_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp machine count into 1..MACHINES
	always_comb begin
		if (machines_used_q == '0) begin
			used = CNT_W'(1);
		end else if (machines_used_q > CNT_W'(MACHINES)) begin
			used = CNT_W'(MACHINES);
		end else begin
			used = machines_used_q;
		end
	end

	// Global advance: move unless the output register is full and stalled
	assign advance  = !vld[MACHINES] || m_tready;
	assign s_tready = advance;

	// Job record entering the first cell
	always_comb begin
		vld[0]       = s_tvalid;
		job[0].first = s_tuser;
		job[0].sat   = 1'b0;
		job[0].proc  = s_tdata;
		job[0].start  = '0;
		job[0].finish = '0;
	end

	// Row of cells
	for (genvar k = 0; k < MACHINES; k++) begin : g_cell
		assign active[k] = (CNT_W'(k) < used);

		always_comb begin
			ctl[k].advance = advance;
			ctl[k].active  = active[k];
			ctl[k].idx     = IDX_W'(k);
			for (int i = 0; i < MACHINES; i++) begin
				ctl[k].pred[i] = (i < k) && pred_mask_q[MACHINES*k + i];
			end
		end

		fsst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.in_valid  (vld[k]),
			.in_job    (job[k]),
			.out_valid (vld[k+1]),
			.out_job   (job[k+1])
		);
	end

	// Output register is the last cell's stage
	assign m_tvalid = vld[MACHINES];
	assign m_tdata  = job[MACHINES].start;
	assign m_tuser  = job[MACHINES].sat;

`ifndef NO_ASSERTIONS
	// A job taken in moves into the first cell stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld[1])
		else $error("accepted job did not enter the first cell");

	// Machine zero of a first job always starts at zero
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && job[MACHINES].first |-> job[MACHINES].start[0] == '0)
		else $error("first job machine 0 start not zero");

	// Unused top machine reports zero start
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (used < CNT_W'(MACHINES)) |->
		job[MACHINES].start[MACHINES-1] == '0)
		else $error("unused machine has nonzero start");

	// Machine 1 never starts before its predecessor, machine 0, finishes
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pred_mask_q[MACHINES] && active[1] |->
		job[MACHINES].start[1] >= job[MACHINES].finish[0])
		else $error("machine 1 starts before machine 0 finishes");
`endif

endmodule

`default_nettype wire

@@ hdl/fsst_cell.sv @@
// One machine cell: earliest start, finish and previous-job finish for one machine.
`timescale 1ns / 1ps
`default_nettype none

module fsst_cell
	import fsst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      in_valid,
	input  job_t      in_job,
	output logic      out_valid,
	output job_t      out_job
);

	logic [TIME_W-1:0] prev_finish_q;
	logic [TIME_W-1:0] es;
	logic [TIME_W:0]   sum;
	job_t              nxt_job;
	logic              out_valid_s1;
	job_t              out_job_s1;

	// Max over predecessor finishes and own previous finish (zero on a first job), then add; inactive cells write zero
	always_comb begin
		es = in_job.first ? '0 : prev_finish_q;
		for (int i = 0; i < MACHINES; i++) begin
			if (ctl.pred[i] && (in_job.finish[i] > es)) begin
				es = in_job.finish[i];
			end
		end
		sum = {1'b0, es} + {{(TIME_W + 1 - PROC_W){1'b0}}, in_job.proc[ctl.idx]};
		nxt_job = in_job;
		if (ctl.active) begin
			nxt_job.start[ctl.idx]  = es;
			nxt_job.finish[ctl.idx] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
			nxt_job.sat             = in_job.sat | sum[TIME_W];
		end else begin
			nxt_job.start[ctl.idx]  = '0;
			nxt_job.finish[ctl.idx] = '0;
		end
	end

	// Keep this machine's finish for the next job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_finish_q <= '0;
		end else if (ctl.advance && in_valid) begin
			prev_finish_q <= nxt_job.finish[ctl.idx];
		end
	end

	// Stage register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (ctl.advance) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			out_job_s1 <= nxt_job;
		end
	end

	assign out_valid = out_valid_s1;
	assign out_job   = out_job_s1;

endmodule

`default_nettype wire

@@ test/tb_flow_shop_start_times_top.sv @@
// Testbench for the flow shop start time block: directed and random jobs checked against a local predictor.
`timescale 1ns / 1ps

module tb_flow_shop_start_times_top;
	import fsst_pkg::*;

	localparam int                TIME_MAX    = (1 << TIME_W) - 1;
	localparam int                CYCLE_LIMIT = 400000;
	localparam int                PRINT_LIMIT = 40;

	typedef logic [MACHINES-1:0][PROC_W-1:0] proc_vec_t;

	typedef struct packed {
		logic                            sat;
		logic [MACHINES-1:0][TIME_W-1:0] start;
	} start_rec_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [MACHINES*PROC_W-1:0] s_tdata   = '0;  // proc_0 .. proc_7
	logic                       s_tuser   = 1'b0;  // first_job
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [MACHINES*TIME_W-1:0] m_tdata;  // start_0 .. start_7
	logic                       m_tuser;  // saturated
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic                       cfg_index = 1'b0;
	logic [CFG_W-1:0]           cfg_data  = '0;

	// Shadow of the block: registers and stored previous-job finishes
	logic [MASK_W-1:0]          pred_mask_shadow;
	logic [CNT_W-1:0]           used_shadow;
	logic [TIME_W-1:0]          prev_finish_shadow [MACHINES];

	start_rec_t                 expected_starts [$];
	int                         errors      = 0;
	int                         cycles      = 0;
	int                         burst_left  = 0;
	int                         stall_mode  = 0;
	int                         stall_count = 0;

	flow_shop_start_times_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result side with a randomly chosen ready pattern
	always @(posedge clk) begin
		stall_count++;
		if (stall_count % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= stall_count[1];
		endcase
	end

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		start_rec_t want;
		logic [TIME_W-1:0] got;
		if (m_tvalid && m_tready) begin
			if (expected_starts.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_starts.pop_front();
				for (int k = 0; k < MACHINES; k++) begin
					got = m_tdata[k*TIME_W +: TIME_W];
					if (got !== want.start[k])
						report_mismatch($sformatf("start_%0d got %0d want %0d",
							k, got, want.start[k]));
				end
				if (m_tuser !== want.sat)
					report_mismatch($sformatf("saturated got %b want %b",
						m_tuser, want.sat));
			end
		end
	end

	// Max-plus recurrence over the machines in use; update stored finishes
	function automatic void predict_start_times(input logic first, input proc_vec_t proc);
		start_rec_t        rec;
		logic [TIME_W-1:0] fin [MACHINES];
		logic [TIME_W-1:0] es;
		logic [TIME_W:0]   sum;
		int                used;
		used = (used_shadow == 0) ? 1 : (used_shadow > MACHINES) ? MACHINES : used_shadow;
		rec = '0;
		for (int k = 0; k < MACHINES; k++)
			fin[k] = '0;
		for (int k = 0; k < used; k++) begin
			es = first ? '0 : prev_finish_shadow[k];
			for (int i = 0; i < k; i++)
				if (pred_mask_shadow[8*k + i] && fin[i] > es)
					es = fin[i];
			rec.start[k] = es;
			sum = {1'b0, es} + proc[k];
			if (sum > TIME_MAX) begin
				fin[k]  = TIME_W'(TIME_MAX);
				rec.sat = 1'b1;
			end else begin
				fin[k] = sum[TIME_W-1:0];
			end
		end
		for (int k = 0; k < MACHINES; k++)
			prev_finish_shadow[k] = fin[k];
		expected_starts = {expected_starts, rec};
	endfunction

	// Send one job in bursts with random gaps; returns at the accepting edge
	task automatic send_job(input logic first, input proc_vec_t proc);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= proc;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		predict_start_times(first, proc);
	endtask

	// Hold off the input until every expected result has come
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_starts.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_PRED_MASK)
			pred_mask_shadow = value[MASK_W-1:0];
		else
			used_shadow = value[CNT_W-1:0];
	endtask

	function automatic logic [MASK_W-1:0] chain_mask();
		logic [MASK_W-1:0] m;
		m = '0;
		for (int k = 0; k < MACHINES; k++)
			for (int i = 0; i < k; i++)
				m[8*k + i] = 1'b1;
		return m;
	endfunction

	function automatic proc_vec_t fill_procs(input logic [PROC_W-1:0] v);
		return {MACHINES{v}};
	endfunction

	function automatic logic [PROC_W-1:0] pick_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return PROC_W'($urandom_range(0, 15));
			default: return PROC_W'($urandom);
		endcase
	endfunction

	function automatic proc_vec_t random_procs();
		proc_vec_t p;
		for (int k = 0; k < MACHINES; k++)
			p[k] = pick_time();
		return p;
	endfunction

	// Reset values: empty mask, all eight machines
	task automatic test_reset_defaults();
		send_job(1'b1, fill_procs('0));
		send_job(1'b0, fill_procs('1));
		send_job(1'b0, random_procs());
		send_job(1'b1, random_procs());
	endtask

	// Masks and machine counts at their extremes
	task automatic test_directed_config();
		write_reg(REG_PRED_MASK, chain_mask());
		send_job(1'b1, fill_procs('1));
		send_job(1'b0, fill_procs('1));
		send_job(1'b0, fill_procs('0));
		// backward and self edges must be ignored
		write_reg(REG_PRED_MASK, '1);
		send_job(1'b0, fill_procs('1));
		send_job(1'b1, random_procs());
		write_reg(REG_PRED_MASK, ~chain_mask());
		send_job(1'b0, random_procs());
		send_job(1'b0, fill_procs('1));
		// zero machines acts as one; upper data bits are dropped
		write_reg(REG_PRED_MASK, chain_mask());
		write_reg(REG_MACHINES_USED, {{(CFG_W-CNT_W){1'b1}}, {CNT_W{1'b0}}});
		send_job(1'b0, fill_procs('1));
		send_job(1'b0, random_procs());
		// count above the machine total acts as the total
		write_reg(REG_MACHINES_USED, CFG_W'(15));
		send_job(1'b0, random_procs());
		send_job(1'b1, fill_procs('1));
		write_reg(REG_MACHINES_USED, CFG_W'(1));
		send_job(1'b0, fill_procs('1));
		send_job(1'b0, random_procs());
		// history must survive an idle input mid-sequence
		write_reg(REG_MACHINES_USED, CFG_W'(3));
		send_job(1'b1, random_procs());
		send_job(1'b0, random_procs());
		wait_for_results();
		send_job(1'b0, random_procs());
		send_job(1'b0, fill_procs('1));
	endtask

	// One long sequence of near-maximum times until the sums clip
	task automatic test_saturation();
		proc_vec_t p;
		write_reg(REG_PRED_MASK, chain_mask());
		write_reg(REG_MACHINES_USED, CFG_W'(MACHINES));
		for (int j = 0; j < 300; j++) begin
			for (int k = 0; k < MACHINES; k++)
				p[k] = ($urandom_range(0, 19) == 0) ? PROC_W'($urandom) : '1;
			send_job(j == 0, p);
		end
	endtask

	// Random settings, each followed by sequences of random jobs
	task automatic test_random_phases();
		logic [MASK_W-1:0] m;
		int                seq_left;
		logic              first;
		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 3))
				0: m = '0;
				1: m = chain_mask() & {$urandom, $urandom};
				2: m = chain_mask();
				default: m = {$urandom, $urandom};
			endcase
			write_reg(REG_PRED_MASK, m);
			case ($urandom_range(0, 4))
				0: write_reg(REG_MACHINES_USED, CFG_W'(0));
				1: write_reg(REG_MACHINES_USED, CFG_W'(1));
				2: write_reg(REG_MACHINES_USED, {$urandom, $urandom});
				default: write_reg(REG_MACHINES_USED, CFG_W'(MACHINES));
			endcase
			seq_left = 0;
			for (int j = 0; j < 45; j++) begin
				first = (seq_left == 0);
				if (first)
					seq_left = $urandom_range(1, 20);
				seq_left--;
				// stray flag now and then breaks a sequence
				if ($urandom_range(0, 15) == 0)
					first = ~first;
				send_job(first, random_procs());
			end
		end
	endtask

	initial begin
		pred_mask_shadow = '0;
		used_shadow      = CNT_W'(MACHINES);
		for (int k = 0; k < MACHINES; k++)
			prev_finish_shadow[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_config();
		test_saturation();
		test_random_phases();
		wait_for_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
